// ===== rtl/msd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package msd_pkg;
  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
endpackage
`default_nettype wire

// ===== rtl/msd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface msd_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [msd_pkg::DATA_W-1:0]  value;
  logic                               last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface
`default_nettype wire

// ===== rtl/msd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface msd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [msd_pkg::DATA_W-1:0]  sorted_value;
  logic                               last_result;
  logic                               overflowed;

  modport source (output valid, output sorted_value, output last_result,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input last_result,
                  input overflowed, output ready);
endinterface
`default_nettype wire

// ===== rtl/merge_sort_descending_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Collects up to MAX_ITEMS signed 32-bit values, one per request, and on the
// request marked last_item sorts them into descending order and returns them
// largest first, the final one marked last_result. Values beyond capacity are
// dropped and every result of that set carries overflowed. While loading, a
// request is accepted whenever one is offered. The sort is bottom-up merging
// through one compare and select unit over two ping-pong buffer banks: each
// merged element is a registered read of both run heads, then a compare and
// write. Each result is then read from the buffer and presented, and is held
// until the sink takes it. No request is taken from the last request of a
// set until its final result has been delivered.
module merge_sort_descending_top #(
  parameter int MAX_ITEMS = msd_pkg::MAX_ITEMS
) (
  input  wire logic  clk,
  input  wire logic  rst,
  msd_in_if.sink     item,
  msd_out_if.source  result
);
  import msd_pkg::*;

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W = CNT_W + 2;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_ORD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [DATA_W-1:0] bank0 [MAX_ITEMS];
  logic [DATA_W-1:0] bank1 [MAX_ITEMS];

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic              src;
  logic [SUM_W-1:0]  width;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  li;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  ri;
  logic [CNT_W-1:0]  hi;
  logic [DATA_W-1:0] rd_l;
  logic [DATA_W-1:0] rd_r;

  logic              in_fire;
  logic              out_fire;
  logic              fits;
  logic [CNT_W-1:0]  count_next;
  logic              dropped_next;
  logic [CNT_W-1:0]  n_src;
  logic [SUM_W-1:0]  seg_lo;
  logic [SUM_W-1:0]  seg_w;
  logic [SUM_W-1:0]  sum_mid;
  logic [SUM_W-1:0]  sum_hi;
  logic [CNT_W-1:0]  seg_mid;
  logic [CNT_W-1:0]  seg_hi;
  logic              take_left;
  logic [DATA_W-1:0] merged;
  logic [CNT_W-1:0]  k_inc;
  logic              seg_end;
  logic              pass_end;
  logic              sort_done;
  logic [SUM_W-1:0]  width_dbl;

  assign in_fire  = item.valid && item.ready;
  assign out_fire = result.valid && result.ready;
  assign fits     = count < CNT_W'(MAX_ITEMS);

  assign count_next   = fits ? count + CNT_W'(1) : count;
  assign dropped_next = dropped | ~fits;

  assign take_left = (li < mid) &&
                     ((ri >= hi) || ($signed(rd_l) > $signed(rd_r)));
  assign merged    = take_left ? rd_l : rd_r;
  assign k_inc     = k + CNT_W'(1);
  assign seg_end   = k_inc == hi;
  assign pass_end  = k_inc == count;
  assign width_dbl = width << 1;
  assign sort_done = width_dbl >= SUM_W'(count);

  // segment bounds for the next merge, clipped to the set size
  always_comb begin
    n_src  = count;
    seg_lo = SUM_W'(hi);
    seg_w  = width;
    if (state == S_LOAD) begin
      n_src  = count_next;
      seg_lo = '0;
      seg_w  = SUM_W'(1);
    end else if (pass_end) begin
      seg_lo = '0;
      seg_w  = width_dbl;
    end
    sum_mid = seg_lo + seg_w;
    sum_hi  = seg_lo + (seg_w << 1);
    seg_mid = (sum_mid > SUM_W'(n_src)) ? n_src : sum_mid[CNT_W-1:0];
    seg_hi  = (sum_hi > SUM_W'(n_src)) ? n_src : sum_hi[CNT_W-1:0];
  end

  assign item.ready          = state == S_LOAD;
  assign result.valid        = state == S_OUT;
  assign result.sorted_value = rd_l;
  assign result.last_result  = k_inc == count;
  assign result.overflowed   = dropped;

  // buffer banks
  always_ff @(posedge clk) begin
    if (state == S_LOAD && in_fire && fits) begin
      bank0[count[IDX_W-1:0]] <= item.value;
    end else if (state == S_CMP) begin
      if (src) begin
        bank0[k[IDX_W-1:0]] <= merged;
      end else begin
        bank1[k[IDX_W-1:0]] <= merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      rd_l <= src ? bank1[li[IDX_W-1:0]] : bank0[li[IDX_W-1:0]];
      rd_r <= src ? bank1[ri[IDX_W-1:0]] : bank0[ri[IDX_W-1:0]];
    end else if (state == S_ORD) begin
      rd_l <= src ? bank1[k[IDX_W-1:0]] : bank0[k[IDX_W-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      dropped <= 1'b0;
      src     <= 1'b0;
      width   <= SUM_W'(1);
      k       <= '0;
      li      <= '0;
      mid     <= '0;
      ri      <= '0;
      hi      <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            count   <= count_next;
            dropped <= dropped_next;
            if (item.last_item) begin
              src   <= 1'b0;
              width <= SUM_W'(1);
              k     <= '0;
              li    <= '0;
              mid   <= seg_mid;
              ri    <= seg_mid;
              hi    <= seg_hi;
              state <= (count_next == CNT_W'(1)) ? S_ORD : S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (take_left) begin
            li <= li + CNT_W'(1);
          end else begin
            ri <= ri + CNT_W'(1);
          end
          if (pass_end) begin
            src   <= ~src;
            width <= width_dbl;
            k     <= '0;
            li    <= '0;
            mid   <= seg_mid;
            ri    <= seg_mid;
            hi    <= seg_hi;
            state <= sort_done ? S_ORD : S_RD;
          end else begin
            k <= k_inc;
            if (seg_end) begin
              li  <= hi;
              mid <= seg_mid;
              ri  <= seg_mid;
              hi  <= seg_hi;
            end
            state <= S_RD;
          end
        end
        S_ORD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) begin
            if (k_inc == count) begin
              count   <= '0;
              dropped <= 1'b0;
              src     <= 1'b0;
              k       <= '0;
              state   <= S_LOAD;
            end else begin
              k     <= k_inc;
              state <= S_ORD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end
endmodule
`default_nettype wire
